/* rtl/wto_pkg.sv */
// ----------------------------------------------------------------------------
// wto_pkg
// Shared types and constants for the two-wheel tab odometer.
// ----------------------------------------------------------------------------
package wto_pkg;

  // bridge drive codes
  typedef enum logic [1:0] {
    MODE_STANDBY  = 2'd0,
    MODE_FORWARD  = 2'd1,
    MODE_BACKWARD = 2'd2
  } mode_e;

  // item kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  // debounce threshold after reset
  localparam logic [7:0] DEBOUNCE_RESET = 8'd10;

  // per-wheel status handed from the wheel unit to the result stage
  typedef struct packed {
    mode_e mode;
    logic  on_tab;
    logic  counted;
  } wheel_stat_t;

endpackage

/* rtl/wheel_tab_odometer_stop.sv */
// ----------------------------------------------------------------------------
// wheel_tab_odometer_stop
// Two-wheel tab odometer: start loads counts and directions, ticks debounce
// the comparators, count tabs and put finished wheels in standby.
// ----------------------------------------------------------------------------
// stages: input register, then result register; the wheel state is updated as
//   the result loads; one item per cycle, limited by the single result register
//   and stalled while out_ready_i holds back a valid result
// reset: wheels in standby with zero counts and clear filters, debounce
//   threshold 10, both pipeline stages empty; no clearing pass
module wheel_tab_odometer_stop import wto_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // input items
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic        left_tab_i,
  input  logic        right_tab_i,
  input  logic [15:0] tab_count_i,
  input  logic        left_reverse_i,
  input  logic        right_reverse_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  left_drive_o,
  output logic [1:0]  right_drive_o,
  output logic [15:0] left_remaining_o,
  output logic [15:0] right_remaining_o,
  output logic        left_on_tab_o,
  output logic        right_on_tab_o,
  output logic        left_counted_o,
  output logic        right_counted_o,
  output logic        busy_res_o
);

  logic [7:0]             debounce_q;
  logic                   s1_valid_q;
  logic                   s1_kind_q, s1_ltab_q, s1_rtab_q, s1_lrev_q, s1_rrev_q;
  logic [COUNT_WIDTH-1:0] s1_cnt_q;
  logic [31:0]            cnt_wide;
  logic                   in_fire, res_load;
  logic                   busy, start, tick;
  logic [COUNT_WIDTH-1:0] l_tabs, r_tabs;
  logic [31:0]            l_rem_wide, r_rem_wide;
  wheel_stat_t            l_stat, r_stat;
  mode_e                  l_mode, r_mode;

  // config register, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      debounce_q <= cfg_data_i;
    end
  end

  // pipeline handshake
  assign res_load   = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || !out_valid_o || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // input register
  assign cnt_wide = 32'(tab_count_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (res_load) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q <= kind_i;
      s1_ltab_q <= left_tab_i;
      s1_rtab_q <= right_tab_i;
      s1_cnt_q  <= cnt_wide[COUNT_WIDTH-1:0];
      s1_lrev_q <= left_reverse_i;
      s1_rrev_q <= right_reverse_i;
    end
  end

  // item decode against current wheel state
  assign busy  = (l_mode != MODE_STANDBY) || (r_mode != MODE_STANDBY);
  assign start = s1_kind_q == KIND_START;
  assign tick  = (s1_kind_q == KIND_TICK) && busy;

  wto_wheel #(.COUNT_WIDTH(COUNT_WIDTH)) u_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (res_load),
    .start_i   (start),
    .tick_i    (tick),
    .level_i   (s1_ltab_q),
    .count_i   (s1_cnt_q),
    .reverse_i (s1_lrev_q),
    .thresh_i  (debounce_q),
    .tabs_o    (l_tabs),
    .stat_o    (l_stat),
    .mode_o    (l_mode)
  );

  wto_wheel #(.COUNT_WIDTH(COUNT_WIDTH)) u_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (res_load),
    .start_i   (start),
    .tick_i    (tick),
    .level_i   (s1_rtab_q),
    .count_i   (s1_cnt_q),
    .reverse_i (s1_rrev_q),
    .thresh_i  (debounce_q),
    .tabs_o    (r_tabs),
    .stat_o    (r_stat),
    .mode_o    (r_mode)
  );

  assign l_rem_wide = 32'(l_tabs);
  assign r_rem_wide = 32'(r_tabs);

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (res_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      left_drive_o      <= l_stat.mode;
      right_drive_o     <= r_stat.mode;
      left_remaining_o  <= l_rem_wide[15:0];
      right_remaining_o <= r_rem_wide[15:0];
      left_on_tab_o     <= l_stat.on_tab;
      right_on_tab_o    <= r_stat.on_tab;
      left_counted_o    <= l_stat.counted;
      right_counted_o   <= r_stat.counted;
      busy_res_o        <= (l_stat.mode != MODE_STANDBY) || (r_stat.mode != MODE_STANDBY);
    end
  end

  // checks
  a_left_count_on_tab: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && left_counted_o |-> left_on_tab_o)
    else $error("left tab counted while not on tab");

  a_right_count_on_tab: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && right_counted_o |-> right_on_tab_o)
    else $error("right tab counted while not on tab");

  a_busy_matches_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_res_o == ((left_drive_o != MODE_STANDBY) ||
                                   (right_drive_o != MODE_STANDBY)))
    else $error("busy flag disagrees with drive modes");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && s1_valid_q && !out_ready_i)
    else $error("input stalled without a blocked result");

endmodule

/* rtl/wto_wheel.sv */
// ----------------------------------------------------------------------------
// wto_wheel
// One wheel: debounce filter, tab state, remaining count and drive mode.
// Next values are computed combinationally and committed on load_i.
// ----------------------------------------------------------------------------
module wto_wheel import wto_pkg::*; #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   load_i,
  input  logic                   start_i,
  input  logic                   tick_i,
  input  logic                   level_i,
  input  logic [COUNT_WIDTH-1:0] count_i,
  input  logic                   reverse_i,
  input  logic [7:0]             thresh_i,
  output logic [COUNT_WIDTH-1:0] tabs_o,
  output wheel_stat_t            stat_o,
  output mode_e                  mode_o
);

  logic                   tab_state_q, tab_state_d;
  logic [7:0]             filt_q, filt_d;
  logic [COUNT_WIDTH-1:0] tabs_q, tabs_d;
  mode_e                  mode_q, mode_d;
  logic                   counted;
  logic [8:0]             filt_inc;

  assign filt_inc = {1'b0, filt_q} + 9'd1;

  // start, debounce and count update
  always_comb begin
    tab_state_d = tab_state_q;
    filt_d      = filt_q;
    tabs_d      = tabs_q;
    mode_d      = mode_q;
    counted     = 1'b0;
    if (start_i) begin
      tabs_d      = count_i;
      mode_d      = reverse_i ? MODE_BACKWARD : MODE_FORWARD;
      filt_d      = '0;
      tab_state_d = level_i;
    end else if (tick_i) begin
      if (level_i == tab_state_q) begin
        filt_d = '0;
      end else if (filt_inc >= {1'b0, thresh_i}) begin
        filt_d      = '0;
        tab_state_d = level_i;
        if (level_i && (tabs_q != '0)) begin
          tabs_d  = tabs_q - COUNT_WIDTH'(1);
          counted = 1'b1;
        end
      end else begin
        filt_d = filt_inc[7:0];
      end
      // wheel stops once its count is used up
      if (tabs_d == '0) begin
        mode_d = MODE_STANDBY;
      end
    end
  end

  // wheel state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_state_q <= 1'b0;
      filt_q      <= '0;
      tabs_q      <= '0;
      mode_q      <= MODE_STANDBY;
    end else if (load_i) begin
      tab_state_q <= tab_state_d;
      filt_q      <= filt_d;
      tabs_q      <= tabs_d;
      mode_q      <= mode_d;
    end
  end

  assign tabs_o         = tabs_d;
  assign stat_o.mode    = mode_d;
  assign stat_o.on_tab  = tab_state_d;
  assign stat_o.counted = counted;
  assign mode_o         = mode_q;

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the two-wheel tab odometer. A short directed table
// covers idle ticks, starts at count extremes, restarts and zero-count tabs.
// Randomized phases follow at several debounce thresholds, each a mix of
// comparator waveforms held near the threshold plus glitches and noise.
// Every result is compared field by field to a typed row or local predictor.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import wto_pkg::*;

  localparam int IDLE_PCT    = 29;
  localparam int HOLD_CYCLES = 40;
  localparam int DRAIN_SLACK = 4;
  localparam int REPORT_MAX  = 10;
  localparam int LIMIT       = 200000;

  // one input transaction
  typedef struct {
    logic        kind;
    logic        ltab;
    logic        rtab;
    logic [15:0] count;
    logic        lrev;
    logic        rrev;
  } odo_item_t;

  // one result transaction
  typedef struct packed {
    mode_e       left_drive;
    mode_e       right_drive;
    logic [15:0] left_rem;
    logic [15:0] right_rem;
    logic        left_on;
    logic        right_on;
    logic        left_cnt;
    logic        right_cnt;
    logic        busy;
  } odo_res_t;

  // directed row: optional threshold write before it, optional typed result
  typedef struct {
    int        thr_write;
    odo_item_t item;
    bit        fixed;
    odo_res_t  res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic        kind_i;
  logic        left_tab_i;
  logic        right_tab_i;
  logic [15:0] tab_count_i;
  logic        left_reverse_i;
  logic        right_reverse_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  left_drive_o;
  logic [1:0]  right_drive_o;
  logic [15:0] left_remaining_o;
  logic [15:0] right_remaining_o;
  logic        left_on_tab_o;
  logic        right_on_tab_o;
  logic        left_counted_o;
  logic        right_counted_o;
  logic        busy_res_o;

  wheel_tab_odometer_stop dut (.*);

  // predicted wheel state, index 0 left, 1 right
  logic        tab_state [2];
  logic [7:0]  filt_cnt [2];
  logic [15:0] tabs_left [2];
  mode_e       wheel_mode [2];
  logic [7:0]  debounce_cfg;

  odo_res_t    pending_q [$];
  int          fail_cnt = 0;
  int          cycle_cnt = 0;
  bit          hold_req = 0;
  bit          steady = 0;

  // comparator waveform generator state
  logic        gen_lvl [2] = '{1'b0, 1'b0};
  int          gen_run [2] = '{0, 0};

  dir_row_t plan [21] = '{
    // ticks before any move are ignored
    '{-1, '{KIND_TICK, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b0}, 1'b1,
      '{MODE_STANDBY, MODE_STANDBY, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    '{-1, '{KIND_TICK, 1'b1, 1'b1, 16'hFFFF, 1'b1, 1'b1}, 1'b1,
      '{MODE_STANDBY, MODE_STANDBY, 16'h0000, 16'h0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}},
    // start at full count, then restart with zero count
    '{-1, '{KIND_START, 1'b1, 1'b0, 16'hFFFF, 1'b0, 1'b1}, 1'b1,
      '{MODE_FORWARD, MODE_BACKWARD, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{-1, '{KIND_START, 1'b0, 1'b1, 16'h0000, 1'b1, 1'b0}, 1'b1,
      '{MODE_BACKWARD, MODE_FORWARD, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1}},
    // zero count stops both wheels on the next tick
    '{-1, '{KIND_TICK, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0}, 1'b1,
      '{MODE_STANDBY, MODE_STANDBY, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{-1, '{KIND_TICK, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0}, 1'b1,
      '{MODE_STANDBY, MODE_STANDBY, 16'h0000, 16'h0000, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0}},
    '{-1, '{KIND_START, 1'b1, 1'b1, 16'h0001, 1'b0, 1'b0}, 1'b1,
      '{MODE_FORWARD, MODE_FORWARD, 16'h0001, 16'h0001, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1}},
    '{-1, '{KIND_TICK, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0}, 1'b0, '0},
    // threshold one: count both wheels down, left reaches zero first
    '{1, '{KIND_START, 1'b0, 1'b0, 16'h0002, 1'b1, 1'b0}, 1'b1,
      '{MODE_BACKWARD, MODE_FORWARD, 16'h0002, 16'h0002, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1}},
    '{-1, '{KIND_TICK, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0}, 1'b0, '0},
    '{-1, '{KIND_TICK, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0}, 1'b0, '0},
    '{-1, '{KIND_TICK, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0}, 1'b0, '0},
    '{-1, '{KIND_TICK, 1'b0, 1'b1, 16'h0000, 1'b0, 1'b0}, 1'b0, '0},
    // left in standby still debounced, tab at zero count not counted
    '{-1, '{KIND_TICK, 1'b1, 1'b0, 16'h0000, 1'b0, 1'b0}, 1'b0, '0},
    '{-1, '{KIND_TICK, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b0}, 1'b0, '0},
    '{-1, '{KIND_TICK, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0}, 1'b1,
      '{MODE_STANDBY, MODE_STANDBY, 16'h0000, 16'h0000, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}},
    // restart while busy
    '{-1, '{KIND_START, 1'b1, 1'b1, 16'hFFFF, 1'b0, 1'b0}, 1'b1,
      '{MODE_FORWARD, MODE_FORWARD, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1}},
    '{-1, '{KIND_TICK, 1'b0, 1'b0, 16'h0000, 1'b0, 1'b0}, 1'b0, '0},
    '{-1, '{KIND_TICK, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b0}, 1'b0, '0},
    '{-1, '{KIND_START, 1'b0, 1'b1, 16'h0001, 1'b1, 1'b1}, 1'b1,
      '{MODE_BACKWARD, MODE_BACKWARD, 16'h0001, 16'h0001, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1}},
    '{-1, '{KIND_TICK, 1'b1, 1'b1, 16'h0000, 1'b0, 1'b0}, 1'b0, '0}
  };

  // debounce one wheel, returns 1 when a tab was counted
  function automatic logic debounce_wheel(int w, logic level);
    if (level == tab_state[w]) begin
      filt_cnt[w] = '0;
      return 1'b0;
    end
    if (int'(filt_cnt[w]) + 1 >= int'(debounce_cfg)) begin
      filt_cnt[w]  = '0;
      tab_state[w] = level;
      if (level && tabs_left[w] != '0) begin
        tabs_left[w] = tabs_left[w] - 16'd1;
        return 1'b1;
      end
      return 1'b0;
    end
    filt_cnt[w] = filt_cnt[w] + 8'd1;
    return 1'b0;
  endfunction

  // advance the predicted odometer by one item, return the status it shows
  function automatic odo_res_t odometer_step(odo_item_t it);
    odo_res_t r;
    logic     was_busy;
    logic     lc;
    logic     rc;
    r        = '0;
    lc       = 1'b0;
    rc       = 1'b0;
    was_busy = (wheel_mode[0] != MODE_STANDBY) || (wheel_mode[1] != MODE_STANDBY);
    if (it.kind == KIND_START) begin
      tabs_left[0]  = it.count;
      tabs_left[1]  = it.count;
      wheel_mode[0] = it.lrev ? MODE_BACKWARD : MODE_FORWARD;
      wheel_mode[1] = it.rrev ? MODE_BACKWARD : MODE_FORWARD;
      filt_cnt[0]   = '0;
      filt_cnt[1]   = '0;
      tab_state[0]  = it.ltab;
      tab_state[1]  = it.rtab;
    end else if (was_busy) begin
      lc = debounce_wheel(0, it.ltab);
      rc = debounce_wheel(1, it.rtab);
      for (int w = 0; w < 2; w++) begin
        if (tabs_left[w] == '0) wheel_mode[w] = MODE_STANDBY;
      end
    end
    r.left_drive  = wheel_mode[0];
    r.right_drive = wheel_mode[1];
    r.left_rem    = tabs_left[0];
    r.right_rem   = tabs_left[1];
    r.left_on     = tab_state[0];
    r.right_on    = tab_state[1];
    r.left_cnt    = lc;
    r.right_cnt   = rc;
    r.busy        = (wheel_mode[0] != MODE_STANDBY) || (wheel_mode[1] != MODE_STANDBY);
    return r;
  endfunction

  // offer one item, record the expected status once it is taken
  task automatic send_item(odo_item_t it, bit fixed, odo_res_t want);
    odo_res_t pred;
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i      <= 1'b1;
    kind_i          <= it.kind;
    left_tab_i      <= it.ltab;
    right_tab_i     <= it.rtab;
    tab_count_i     <= it.count;
    left_reverse_i  <= it.lrev;
    right_reverse_i <= it.rrev;
    do @(posedge clk_i); while (!in_ready_o);
    pred = odometer_step(it);
    pending_q.push_back(fixed ? want : pred);
  endtask

  // stop offering and wait for the pipeline to empty
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_SLACK) @(posedge clk_i);
  endtask

  task automatic write_debounce(logic [7:0] thr);
    settle_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= thr;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    debounce_cfg = thr;
  endtask

  // random moves: comparator runs near the threshold, glitches and noise
  task automatic random_phase(logic [7:0] thr, int n_items, bit with_hold, bit with_drain);
    odo_item_t it;
    int        done;
    int        thr_eff;
    int        pick;
    bit        busy_now;
    bit        held;
    bit        drained;
    write_debounce(thr);
    thr_eff = (thr == 8'd0) ? 1 : int'(thr);
    done    = 0;
    held    = 1'b0;
    drained = 1'b0;
    while (done < n_items) begin
      busy_now = (wheel_mode[0] != MODE_STANDBY) || (wheel_mode[1] != MODE_STANDBY);
      for (int w = 0; w < 2; w++) begin
        if (gen_run[w] == 0) begin
          gen_lvl[w] = !gen_lvl[w];
          gen_run[w] = ($urandom_range(0, 99) < 80) ?
                       $urandom_range(thr_eff, thr_eff + 3) : $urandom_range(1, thr_eff);
        end
        gen_run[w]--;
      end
      it.ltab = gen_lvl[0];
      it.rtab = gen_lvl[1];
      if ($urandom_range(0, 99) < 10) begin
        it.ltab = 1'($urandom_range(0, 1));
        it.rtab = 1'($urandom_range(0, 1));
      end
      it.lrev  = 1'($urandom_range(0, 1));
      it.rrev  = 1'($urandom_range(0, 1));
      it.count = 16'($urandom);
      it.kind  = KIND_TICK;
      if ($urandom_range(0, 99) < (busy_now ? 2 : 90)) begin
        it.kind = KIND_START;
        pick    = $urandom_range(0, 99);
        if (thr_eff > 40 && pick < 95) it.count = 16'($urandom_range(0, 2));
        else if (pick < 70)            it.count = 16'($urandom_range(0, 5));
        else if (pick < 85)            it.count = 16'($urandom_range(6, 40));
        else if (pick >= 95)           it.count = 16'hFFFF;
      end
      if (busy_now || it.kind == KIND_START) done++;
      // long receiver stall while items keep coming
      if (with_hold && !held && done >= n_items / 2) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      if (with_drain && !drained && done >= 3 * n_items / 4) begin
        settle_idle();
        drained = 1'b1;
      end
      send_item(it, 1'b0, '0);
    end
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result receiver: random back-pressure, always ready when steady, long hold on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (steady) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // compare each result transaction with the oldest expected status
  always @(posedge clk_i) begin : check_results
    odo_res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX) $display("unexpected result at cycle %0d", cycle_cnt);
      end else begin
        want = pending_q.pop_front();
        if (left_drive_o !== want.left_drive || right_drive_o !== want.right_drive ||
            left_remaining_o !== want.left_rem || right_remaining_o !== want.right_rem ||
            left_on_tab_o !== want.left_on || right_on_tab_o !== want.right_on ||
            left_counted_o !== want.left_cnt || right_counted_o !== want.right_cnt ||
            busy_res_o !== want.busy) begin
          fail_cnt++;
          if (fail_cnt <= REPORT_MAX) begin
            $display("mismatch at cycle %0d", cycle_cnt);
            $display("  expected drive %0d/%0d rem %0d/%0d on %b/%b counted %b/%b busy %b",
                     want.left_drive, want.right_drive, want.left_rem, want.right_rem,
                     want.left_on, want.right_on, want.left_cnt, want.right_cnt, want.busy);
            $display("  actual   drive %0d/%0d rem %0d/%0d on %b/%b counted %b/%b busy %b",
                     left_drive_o, right_drive_o, left_remaining_o, right_remaining_o,
                     left_on_tab_o, right_on_tab_o, left_counted_o, right_counted_o,
                     busy_res_o);
          end
        end
      end
    end
  end

  // stimulus
  initial begin
    rst_ni          = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    kind_i          = KIND_TICK;
    left_tab_i      = 1'b0;
    right_tab_i     = 1'b0;
    tab_count_i     = '0;
    left_reverse_i  = 1'b0;
    right_reverse_i = 1'b0;
    for (int w = 0; w < 2; w++) begin
      tab_state[w]  = 1'b0;
      filt_cnt[w]   = '0;
      tabs_left[w]  = '0;
      wheel_mode[w] = MODE_STANDBY;
    end
    debounce_cfg = DEBOUNCE_RESET;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (plan[i]) begin
      if (plan[i].thr_write >= 0) write_debounce(8'(plan[i].thr_write));
      send_item(plan[i].item, plan[i].fixed, plan[i].res);
    end

    // random phases across thresholds, extremes included
    random_phase(8'd1, 300, 1'b1, 1'b1);
    random_phase(8'd0, 150, 1'b0, 1'b0);
    random_phase(8'd255, 330, 1'b0, 1'b0);
    steady = 1'b1;
    random_phase(8'($urandom_range(2, 12)), 300, 1'b0, 1'b0);
    steady = 1'b0;
    random_phase(DEBOUNCE_RESET, 350, 1'b1, 1'b0);

    settle_idle();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
